[rtl/rtpjt_pkg.sv]
// Shared types, constants and helpers for the RTP jitter and loss tracker.
`timescale 1ns / 1ps
package rtpjt_pkg;

  localparam int GapSlots = 16;
  localparam int SlotW    = $clog2(GapSlots);
  localparam int CountW   = $clog2(GapSlots + 1);

  localparam logic [1:0] OpArrive  = 2'd0;
  localparam logic [1:0] OpHarvest = 2'd1;
  localparam logic [1:0] OpClear   = 2'd2;
  localparam logic [1:0] OpNone    = 2'd3;

  localparam logic [63:0] SpacingMax = 64'h8000_0000_0000_0000;
  localparam logic [31:0] NsPerSec   = 32'd1_000_000_000;
  localparam logic [11:0] LostMax    = 12'hFFF;

  // Input payload, last field lowest.
  typedef struct packed {
    logic        discard_mark;
    logic        gap_mark;
    logic [63:0] threshold_ns;
    logic [63:0] now_ns;
    logic [63:0] recv_time;
    logic [63:0] send_time;
    logic [15:0] seq_num;
    logic [1:0]  opcode;
  } req_t;

  // Result payload, last field lowest.
  typedef struct packed {
    logic        first_packet;
    logic [11:0] lost_total;
    logic [31:0] jitter_value;
    logic [63:0] delay_ns;
    logic [63:0] skew_ns;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the request and compute stage-one values
    logic conv_delay; // multiply steps for delay
    logic conv_skew;  // multiply steps for skew
    logic arrive_fin; // commit arrival state, decide gap work
    logic fill_step;  // examine one gap entry for a fill
    logic shift_step; // close up one entry after removal
    logic harv_step;  // examine head entry for harvest
    logic clear_q;    // clear queue flag
    logic [1:0] mstep;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_done;
    logic fill_remove;
    logic shift_done;
    logic harv_done;
    logic gap_work_fill;
  } sts_t;

  function automatic logic seq_before(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    return d[15];
  endfunction

endpackage

[rtl/rtpjt_ctrl.sv]
// Controller state machine for the RTP jitter and loss tracker.
`timescale 1ns / 1ps
module rtpjt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic [1:0]     opcode_i,
  output logic           req_ready_o,
  input  logic           rsp_free_i,
  output logic           rsp_load_o,
  output rtpjt_pkg::cmd_t cmd_o,
  input  rtpjt_pkg::sts_t sts_i
);
  import rtpjt_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StConvD = 3'd1;
  localparam logic [2:0] StConvS = 3'd2;
  localparam logic [2:0] StFin   = 3'd3;
  localparam logic [2:0] StFill  = 3'd4;
  localparam logic [2:0] StShift = 3'd5;
  localparam logic [2:0] StHarv  = 3'd6;
  localparam logic [2:0] StOut   = 3'd7;

  logic [2:0] state_q, state_d;
  logic [1:0] step_q, step_d;
  logic [1:0] op_q, op_d;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    op_d        = op_q;
    cmd_o       = '0;
    cmd_o.mstep = step_q;
    rsp_load_o  = 1'b0;
    req_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          op_d       = opcode_i;
          step_d     = '0;
          case (opcode_i)
            OpArrive:  state_d = StConvD;
            OpHarvest: state_d = StHarv;
            default:   state_d = StOut;
          endcase
        end
      end
      StConvD: begin
        cmd_o.conv_delay = 1'b1;
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) state_d = StConvS;
      end
      StConvS: begin
        cmd_o.conv_skew = 1'b1;
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) state_d = StFin;
      end
      StFin: begin
        cmd_o.arrive_fin = 1'b1;
        state_d = sts_i.gap_work_fill ? StFill : StOut;
      end
      StFill: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.fill_remove) state_d = StShift;
        else if (sts_i.fill_done) state_d = StOut;
      end
      StShift: begin
        cmd_o.shift_step = 1'b1;
        if (sts_i.shift_done) state_d = StOut;
      end
      StHarv: begin
        cmd_o.harv_step = 1'b1;
        if (sts_i.harv_done) state_d = StOut;
      end
      StOut: begin
        if (rsp_free_i) begin
          rsp_load_o    = 1'b1;
          cmd_o.clear_q = (op_q == OpClear);
          state_d       = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
      op_q    <= OpArrive;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      op_q    <= op_d;
    end
  end

endmodule

[rtl/rtpjt_dp.sv]
// Datapath for the RTP jitter and loss tracker: conversions, jitter, gap table.
`timescale 1ns / 1ps
module rtpjt_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rtpjt_pkg::req_t  req_i,
  input  rtpjt_pkg::cmd_t  cmd_i,
  output rtpjt_pkg::sts_t  sts_o,
  output rtpjt_pkg::rsp_t  rsp_o
);
  import rtpjt_pkg::*;

  // Request capture
  logic [1:0]  op_q;
  logic [15:0] seq_q;
  logic [63:0] now_q, thr_q;
  logic [63:0] delay_ntp_q, skew_ntp_q;
  logic        skew_ok_q;

  // Architectural state
  logic        qne_q, pgap_q, pdis_q;
  logic [15:0] prev_seq_q;
  logic [63:0] prev_send_q, prev_recv_q;
  logic [31:0] jit_q;

  // Gap table
  logic [15:0] g_start_q [GapSlots];
  logic [15:0] g_end_q   [GapSlots];
  logic [7:0]  g_size_q  [GapSlots];
  logic [7:0]  g_fill_q  [GapSlots];
  logic [63:0] g_crt_q   [GapSlots];
  logic [SlotW-1:0]  head_q;
  logic [CountW-1:0] cnt_q;
  logic [CountW-1:0] k_q;

  // Results
  logic [63:0] delay_ns_q, skew_ns_q;
  logic [12:0] lost_q;
  logic        first_q;

  // Stage-one values
  logic [63:0] rdiff, sdiff, sk;
  assign rdiff = req_i.recv_time - prev_recv_q;
  assign sdiff = (prev_send_q < req_i.send_time) ? req_i.send_time - prev_send_q
                                                  : prev_send_q - req_i.send_time;
  assign sk    = (rdiff < sdiff) ? sdiff - rdiff : rdiff - sdiff;

  // Shared 32x32 multiplier, one per cycle; step 0 seconds, step 1 fraction
  logic [63:0] mul_src;
  logic [31:0] mul_a;
  logic [63:0] mul_p;
  assign mul_src = cmd_i.conv_delay ? delay_ntp_q : skew_ntp_q;
  assign mul_a   = cmd_i.mstep[0] ? mul_src[31:0] : mul_src[63:32];
  assign mul_p   = mul_a * NsPerSec;

  logic [63:0] acc_q;
  logic [63:0] conv_res;
  assign conv_res = acc_q + {32'd0, mul_p[63:32]};

  // Jitter update
  logic [36:0] jsum;
  logic [60:0] jv;
  assign jsum = 37'(jit_q) * 37'd15 + 37'(skew_ntp_q[3:0]);
  assign jv   = 61'(skew_ntp_q[63:4]) + 61'(jsum[36:4]);

  // Slot lookups
  logic [SlotW-1:0] slot_k, slot_k1, slot_last, slot_new;
  assign slot_k    = head_q + k_q[SlotW-1:0];
  assign slot_k1   = head_q + k_q[SlotW-1:0] + SlotW'(1);
  assign slot_last = head_q + cnt_q[SlotW-1:0] - SlotW'(1);
  assign slot_new  = head_q + cnt_q[SlotW-1:0];

  logic [15:0] gdiff;
  logic [7:0]  fill_inc;
  logic        in_k, before_k, after_k;
  assign before_k = seq_before(seq_q, g_start_q[slot_k]);
  assign after_k  = seq_before(g_end_q[slot_k], seq_q);
  assign fill_inc = g_fill_q[slot_k] + 8'd1;
  assign in_k     = (k_q < cnt_q) && !before_k && !after_k;
  assign gdiff    = seq_q - prev_seq_q - 16'd1;

  logic harv_take;
  assign harv_take = (cnt_q != '0) && !(thr_q < g_crt_q[head_q]);

  // Fill search runs when a discard mark is pending and no gap mark takes priority.
  assign sts_o.gap_work_fill = qne_q && !pgap_q && pdis_q;
  assign sts_o.fill_done     = (k_q >= cnt_q) || before_k || !after_k;
  assign sts_o.fill_remove   = in_k && !(fill_inc < g_size_q[slot_k]);
  assign sts_o.shift_done    = !(k_q + CountW'(2) < cnt_q);
  assign sts_o.harv_done     = !harv_take;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q        <= req_i.opcode;
      seq_q       <= req_i.seq_num;
      now_q       <= req_i.now_ns;
      thr_q       <= req_i.threshold_ns;
      delay_ntp_q <= req_i.recv_time - req_i.send_time;
      skew_ntp_q  <= sk;
      skew_ok_q   <= qne_q && !(rdiff > SpacingMax);
      acc_q       <= '0;
      lost_q      <= '0;
      skew_ns_q   <= '0;
      delay_ns_q  <= '0;
      first_q     <= (req_i.opcode == OpArrive) && !qne_q;
    end
    if (cmd_i.conv_delay || cmd_i.conv_skew) begin
      case (cmd_i.mstep)
        2'd0: acc_q <= mul_p;
        2'd1: begin
          if (cmd_i.conv_delay) delay_ns_q <= conv_res;
          else if (skew_ok_q) skew_ns_q <= conv_res;
          acc_q <= '0;
        end
        default: ;
      endcase
    end
    if (cmd_i.arrive_fin && qne_q && pgap_q && cnt_q < CountW'(GapSlots) &&
        !(cnt_q != '0 && seq_before(prev_seq_q, g_end_q[slot_last]))) begin
      g_start_q[slot_new] <= prev_seq_q;
      g_end_q[slot_new]   <= seq_q;
      g_size_q[slot_new]  <= (prev_seq_q == seq_q) ? 8'd0 : gdiff[7:0];
      g_fill_q[slot_new]  <= 8'd0;
      g_crt_q[slot_new]   <= now_q;
    end
    if (cmd_i.fill_step && in_k) g_fill_q[slot_k] <= fill_inc;
    if (cmd_i.shift_step && (k_q + CountW'(1) < cnt_q)) begin
      g_start_q[slot_k] <= g_start_q[slot_k1];
      g_end_q[slot_k]   <= g_end_q[slot_k1];
      g_size_q[slot_k]  <= g_size_q[slot_k1];
      g_fill_q[slot_k]  <= g_fill_q[slot_k1];
      g_crt_q[slot_k]   <= g_crt_q[slot_k1];
    end
    if (cmd_i.harv_step && harv_take) begin
      lost_q <= (lost_q + 13'(g_size_q[head_q] - g_fill_q[head_q]) > 13'(LostMax))
                ? 13'(LostMax) : lost_q + 13'(g_size_q[head_q] - g_fill_q[head_q]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qne_q       <= 1'b0;
      pgap_q      <= 1'b0;
      pdis_q      <= 1'b0;
      prev_seq_q  <= '0;
      prev_send_q <= '0;
      prev_recv_q <= '0;
      jit_q       <= '0;
      head_q      <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
    end else begin
      if (cmd_i.load && req_i.opcode == OpArrive) begin
        prev_send_q <= req_i.send_time;
        prev_recv_q <= req_i.recv_time;
        if (req_i.gap_mark) pgap_q <= 1'b1;
        if (req_i.discard_mark) pdis_q <= 1'b1;
      end
      if (cmd_i.arrive_fin) begin
        k_q <= '0;
        if (qne_q) begin
          if (skew_ok_q) jit_q <= (jv > 61'hFFFF_FFFF) ? 32'hFFFF_FFFF : jv[31:0];
          if (pgap_q) begin
            pgap_q <= 1'b0;
            if (cnt_q < CountW'(GapSlots) &&
                !(cnt_q != '0 && seq_before(prev_seq_q, g_end_q[slot_last])))
              cnt_q <= cnt_q + CountW'(1);
          end else if (pdis_q) begin
            pdis_q <= 1'b0;
          end
        end
        qne_q      <= 1'b1;
        prev_seq_q <= seq_q;
      end
      if (cmd_i.fill_step && !sts_o.fill_remove && !sts_o.fill_done)
        k_q <= k_q + CountW'(1);
      if (cmd_i.shift_step) begin
        if (sts_o.shift_done) cnt_q <= cnt_q - CountW'(1);
        else k_q <= k_q + CountW'(1);
      end
      if (cmd_i.harv_step && harv_take) begin
        head_q <= head_q + SlotW'(1);
        cnt_q  <= cnt_q - CountW'(1);
      end
      if (cmd_i.clear_q) qne_q <= 1'b0;
    end
  end

  assign rsp_o.skew_ns      = (op_q == OpArrive) ? skew_ns_q : '0;
  assign rsp_o.delay_ns     = (op_q == OpArrive) ? delay_ns_q : '0;
  assign rsp_o.jitter_value = jit_q;
  assign rsp_o.lost_total   = (op_q == OpHarvest) ? lost_q[11:0] : '0;
  assign rsp_o.first_packet = first_q;

endmodule

[rtl/rtp_jitter_and_loss_tracker.sv]
// Top level of the RTP jitter and loss tracker.
`timescale 1ns / 1ps
// Sequencing: clear goes straight to the result; harvest walks the popped gaps;
//   arrival runs multiplier steps, a fill search and a close-up walk over up to 16 slots.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: rst_ni asynchronous low; clears control, history, jitter and gap pointers.
module rtp_jitter_and_loss_tracker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode, seq_num, send_time, recv_time, now_ns, threshold_ns, gap_mark,
  // discard_mark (lowest first), zero padded to 288 bits
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // skew_ns, delay_ns, jitter_value, lost_total, first_packet (lowest first),
  // zero padded to 176 bits
  output logic [175:0] m_axis_tdata
);
  import rtpjt_pkg::*;

  req_t req;
  cmd_t cmd;
  sts_t sts;
  rsp_t rsp;
  logic rsp_load;
  logic out_valid_q;
  rsp_t out_q;

  assign req = req_t'(s_axis_tdata[$bits(req_t)-1:0]);

  // Controller: sequences the multiplier, fill search and harvest walk.
  rtpjt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .opcode_i    (req.opcode),
    .req_ready_o (s_axis_tready),
    .rsp_free_i  (!out_valid_q || m_axis_tready),
    .rsp_load_o  (rsp_load),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Datapath: holds history, jitter and the gap table.
  rtpjt_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp)
  );

  // Output register: hold the result until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) out_q <= rsp;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, out_q};

endmodule
